// ===== src/binc_pkg.sv =====
// ----------------------------------------------------------------------------
// binc_pkg
// Shared widths, result kinds and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package binc_pkg;

    localparam int N_BITS          = 31;  // n and r field width
    localparam int COEF_BITS       = 63;  // coefficient field width
    localparam int RESULT_BITS_DEF = 64;  // signed result width, sets the limit
    localparam int CHUNK_BITS      = 32;  // multiplier slice width

    // which value a finished item returns
    typedef enum logic [1:0] {
        RES_ONE,
        RES_OVF,
        RES_QUO
    } t_kind;

    // controller -> datapath
    typedef struct packed {
        logic  load;        // capture n, r; derive k
        logic  mul_start;   // load multiplicand, clear accumulator
        logic  mul_den;     // multiplicand is the denominator, not numerator
        logic  mul_step;    // one slice of the product
        logic  num_commit;  // take product into numerator, next factor
        logic  den_init;    // start k! with factor k
        logic  den_commit;  // take product into denominator, next factor
        logic  div_init;    // set up the restoring divider
        logic  div_step;    // one quotient bit
        logic  out_write;   // load output register
        t_kind kind;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic trivial;   // r > n or reduced r is zero
        logic mul_last;  // last slice in flight
        logic ovf;       // conservative product test tripped
        logic fac_last;  // last factor of the current product
        logic div_last;  // last quotient bit in flight
    } t_sts;

endpackage

// ===== src/binc_in_if.sv =====
// ----------------------------------------------------------------------------
// binc_in_if
// Request channel: n and r with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface binc_in_if;
    import binc_pkg::*;

    logic              valid;
    logic              ready;
    logic [N_BITS-1:0] set_size;
    logic [N_BITS-1:0] choose_count;

    modport source (output valid, output set_size, output choose_count, input ready);
    modport sink   (input valid, input set_size, input choose_count, output ready);
endinterface

// ===== src/binc_out_if.sv =====
// ----------------------------------------------------------------------------
// binc_out_if
// Result channel: coefficient and overflow flag with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface binc_out_if;
    import binc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [COEF_BITS-1:0] coefficient;
    logic                 overflow;

    modport source (output valid, output coefficient, output overflow, input ready);
    modport sink   (input valid, input coefficient, input overflow, output ready);
endinterface

// ===== src/binc_ctrl.sv =====
// ----------------------------------------------------------------------------
// binc_ctrl
// Sequencer: numerator product with overflow test, k!, division, result.
// ----------------------------------------------------------------------------
module binc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  binc_pkg::t_sts  i_sts,
    output binc_pkg::t_cmd  o_cmd
);
    import binc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_NSTART,
        ST_NMUL,
        ST_NCOMMIT,
        ST_DSTART,
        ST_DMUL,
        ST_DCOMMIT,
        ST_DIV,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;
    t_kind  r_kind, n_kind;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_out_valid = r_out_valid && !i_out_ready;
        cmd         = '0;
        cmd.kind    = r_kind;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (i_sts.trivial) begin
                    n_kind  = RES_ONE;
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_NSTART;
                end
            end
            ST_NSTART: begin
                cmd.mul_start = 1'b1;
                n_state       = ST_NMUL;
            end
            ST_NMUL: begin
                cmd.mul_step = 1'b1;
                if (i_sts.mul_last) begin
                    n_state = ST_NCOMMIT;
                end
            end
            ST_NCOMMIT: begin
                if (i_sts.ovf) begin
                    n_kind  = RES_OVF;
                    n_state = ST_FINISH;
                end else if (i_sts.fac_last) begin
                    cmd.num_commit = 1'b1;
                    cmd.den_init   = 1'b1;
                    n_state        = ST_DSTART;
                end else begin
                    cmd.num_commit = 1'b1;
                    n_state        = ST_NSTART;
                end
            end
            ST_DSTART: begin
                cmd.mul_start = 1'b1;
                cmd.mul_den   = 1'b1;
                n_state       = ST_DMUL;
            end
            ST_DMUL: begin
                cmd.mul_step = 1'b1;
                if (i_sts.mul_last) begin
                    n_state = ST_DCOMMIT;
                end
            end
            ST_DCOMMIT: begin
                cmd.den_commit = 1'b1;
                if (i_sts.fac_last) begin
                    cmd.div_init = 1'b1;
                    n_state      = ST_DIV;
                end else begin
                    n_state = ST_DSTART;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_kind  = RES_QUO;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_write = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kind      <= RES_ONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/binc_dp.sv =====
// ----------------------------------------------------------------------------
// binc_dp
// Datapath: sliced multiplier, overflow compare, restoring divider, output reg.
// ----------------------------------------------------------------------------
module binc_dp #(
    parameter int RESULT_BITS = binc_pkg::RESULT_BITS_DEF
) (
    input  logic                           i_clk,
    input  binc_pkg::t_cmd                 i_cmd,
    input  logic [binc_pkg::N_BITS-1:0]    i_set_size,
    input  logic [binc_pkg::N_BITS-1:0]    i_choose_count,
    output binc_pkg::t_sts                 o_sts,
    output logic [binc_pkg::COEF_BITS-1:0] o_coefficient,
    output logic                           o_overflow
);
    import binc_pkg::*;

    localparam int NUM_W = RESULT_BITS - 1;                         // product width
    localparam int NCH   = (NUM_W + CHUNK_BITS - 1) / CHUNK_BITS;   // slices
    localparam int A_W   = NCH * CHUNK_BITS;
    localparam int ACC_W = A_W + N_BITS;
    localparam int CNT_W = $clog2(NCH + 1);
    localparam int BIT_W = $clog2(NUM_W + 1);
    localparam int PP_W  = CHUNK_BITS + N_BITS;
    localparam logic [NUM_W-1:0] LIMIT = '1;

    logic [N_BITS-1:0]    r_k, r_i, r_left;
    logic                 r_trivial;
    logic [NUM_W-1:0]     r_num, r_den, r_rem, r_quo;
    logic [A_W-1:0]       r_a;
    logic [ACC_W-1:0]     r_acc;
    logic [CNT_W-1:0]     r_cnt;
    logic [BIT_W-1:0]     r_bits;
    logic [COEF_BITS-1:0] r_coef;
    logic                 r_ovf;

    logic [N_BITS-1:0]   diff, k_in;
    logic [PP_W-1:0]     pp;
    logic [ACC_W:0]      test_sum;
    logic [NUM_W:0]      rem_sh;
    logic                rem_ge;

    // reduced r
    assign diff = i_set_size - i_choose_count;
    assign k_in = (diff < i_choose_count) ? diff : i_choose_count;

    // one slice product, most significant slice first
    assign pp = r_a[A_W-1 -: CHUNK_BITS] * r_i;

    // p >= floor(L/i)  <=>  p*i + i > L
    assign test_sum = {1'b0, r_acc} + (ACC_W + 1)'(r_i);

    assign rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_trivial <= (i_choose_count > i_set_size) || (k_in == '0);
            r_k       <= k_in;
            r_left    <= k_in;
            r_i       <= i_set_size;
            r_num     <= NUM_W'(1);
        end
        if (i_cmd.mul_start) begin
            r_a   <= i_cmd.mul_den ? A_W'(r_den) : A_W'(r_num);
            r_acc <= '0;
            r_cnt <= CNT_W'(NCH);
        end
        if (i_cmd.mul_step) begin
            r_a   <= r_a << CHUNK_BITS;
            r_acc <= (r_acc << CHUNK_BITS) + ACC_W'(pp);
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.num_commit) begin
            r_num <= r_acc[NUM_W-1:0];
        end
        // k! starts at factor k; otherwise step to the next factor
        if (i_cmd.den_init) begin
            r_den  <= NUM_W'(1);
            r_i    <= r_k;
            r_left <= r_k;
        end else if (i_cmd.num_commit || i_cmd.den_commit) begin
            r_i    <= r_i - 1'b1;
            r_left <= r_left - 1'b1;
        end
        if (i_cmd.den_commit) begin
            r_den <= r_acc[NUM_W-1:0];
        end
        if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_quo  <= r_num;
            r_bits <= BIT_W'(NUM_W);
        end
        if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? NUM_W'(rem_sh - {1'b0, r_den}) : rem_sh[NUM_W-1:0];
            r_quo  <= {r_quo[NUM_W-2:0], rem_ge};
            r_bits <= r_bits - 1'b1;
        end
        if (i_cmd.out_write) begin
            case (i_cmd.kind)
                RES_ONE: begin
                    r_coef <= COEF_BITS'(1);
                    r_ovf  <= 1'b0;
                end
                RES_OVF: begin
                    r_coef <= '0;
                    r_ovf  <= 1'b1;
                end
                RES_QUO: begin
                    r_coef <= COEF_BITS'(r_quo);
                    r_ovf  <= 1'b0;
                end
                default: begin
                    r_coef <= '0;
                    r_ovf  <= 1'b0;
                end
            endcase
        end
    end

    assign o_sts.trivial  = r_trivial;
    assign o_sts.mul_last = (r_cnt == CNT_W'(1));
    assign o_sts.ovf      = (test_sum > (ACC_W + 1)'(LIMIT));
    assign o_sts.fac_last = (r_left == N_BITS'(1));
    assign o_sts.div_last = (r_bits == BIT_W'(1));

    assign o_coefficient = r_coef;
    assign o_overflow    = r_ovf;

endmodule

// ===== src/binomial_coefficient_checked_core.sv =====
// ----------------------------------------------------------------------------
// binomial_coefficient_checked_core
// n choose r with a conservative signed-limit overflow check.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents                 | handshake
//  --------+-----+-------------------------------+------------------
//  i_in    | in  | set_size (n), choose_count (r) | valid & ready
//  o_out   | out | coefficient, overflow         | valid & ready
//
//  Per beat: idle, setup and finish when r > n or reduced r is zero;
//  otherwise a start, one multiply step per slice and a commit per
//  numerator factor and per factor of k!, then one divider step per
//  quotient bit and finish (NCH = ceil((RESULT_BITS-1)/32) slices of the
//  shared 32x31 multiplier). At 64 bits k is at most 14 without overflow.
//  Overflow ends the item at the first factor that trips the test.
//  Reset is synchronous, active low; one request is worked at a time.
//  A finished result sits in the output register while the next request is
//  taken; the block stalls only if a second result is ready before the first
//  beat leaves.
// ----------------------------------------------------------------------------
module binomial_coefficient_checked_core #(
    parameter int RESULT_BITS = binc_pkg::RESULT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    binc_in_if.sink    i_in,
    binc_out_if.source o_out
);
    import binc_pkg::*;

    t_cmd cmd;  // sequencer commands
    t_sts sts;  // datapath status

    // sequencer: ready only when idle, owns the output valid
    binc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // arithmetic: multiplier slices, limit compare, divider, result register
    binc_dp #(
        .RESULT_BITS (RESULT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_set_size     (i_in.set_size),
        .i_choose_count (i_in.choose_count),
        .o_sts          (sts),
        .o_coefficient  (o_out.coefficient),
        .o_overflow     (o_out.overflow)
    );

endmodule

// ===== bench/binomial_coefficient_checked_core_test.sv =====
// ----------------------------------------------------------------------------
// binomial_coefficient_checked_core_test
// Self-checking bench for the n-choose-r core. Requests (n, r) go in on the
// request channel, and each one is also run through a local copy of the
// conservative overflow arithmetic. Every result beat is compared in order
// with the oldest awaited value. Traffic runs in phases with different
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module binomial_coefficient_checked_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import binc_pkg::*;

    localparam int RANDOM_ITEMS = 480;   // spread evenly over the four phases
    localparam int DRAIN_CYCLES = 200;   // quiet window after the last awaited beat
    localparam int STALL_LIMIT  = 5000;  // cycles with no beat on either side

    localparam logic [N_BITS-1:0] N_MAX = '1;

    // one awaited result, with the request kept for the mismatch report
    typedef struct {
        logic [N_BITS-1:0]    n;
        logic [N_BITS-1:0]    r;
        logic [COEF_BITS-1:0] coefficient;
        logic                 overflow;
    } t_awaited;

    // ------------------------------------------------------------------------
    // Ledger of awaited coefficients: computes n choose r the way the core
    // must (same early overflow test), and checks result beats in order.
    // ------------------------------------------------------------------------
    class coefficient_ledger;
        t_awaited awaited[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Falling product n..n-k+1 with the overflow check ahead of each
        // multiply, then exact division by k!.
        static function void choose_with_guard(input logic [N_BITS-1:0] n,
                                               input logic [N_BITS-1:0] r,
                                               output logic [COEF_BITS-1:0] coef,
                                               output logic ovf);
            longint unsigned limit;
            longint unsigned numer;
            longint unsigned denom;
            longint unsigned nn;
            longint unsigned k;
            longint unsigned i;
            limit = (64'd1 << (RESULT_BITS_DEF - 1)) - 64'd1;
            nn    = n;
            numer = 1;
            denom = 1;
            coef  = 1;
            ovf   = 1'b0;
            if (r > n) return;
            k = (nn - r < r) ? nn - r : r;
            if (k == 0) return;
            // k! below 2^63 caps k near 20, so this loop exits early
            for (i = nn; i > nn - k; i--) begin
                if (numer >= limit / i) begin
                    coef = '0;
                    ovf  = 1'b1;
                    return;
                end
                numer = numer * i;
            end
            for (i = 1; i <= k; i++) begin
                denom = denom * i;
            end
            coef = COEF_BITS'(numer / denom);
        endfunction

        function void note_request(logic [N_BITS-1:0] n, logic [N_BITS-1:0] r);
            t_awaited a;
            a.n = n;
            a.r = r;
            choose_with_guard(n, r, a.coefficient, a.overflow);
            awaited.push_back(a);
        endfunction

        function void check_result(logic [COEF_BITS-1:0] coef, logic ovf);
            t_awaited a;
            if (awaited.size() == 0) begin
                $display({"%0t ERROR: unexpected result beat: expected none, ",
                          "got coefficient %0d overflow %0b"}, $time, coef, ovf);
                mismatches++;
                return;
            end
            a = awaited.pop_front();
            if (coef !== a.coefficient) begin
                $display("%0t ERROR: n=%0d r=%0d coefficient: expected %0d, got %0d",
                         $time, a.n, a.r, a.coefficient, coef);
                mismatches++;
            end
            if (ovf !== a.overflow) begin
                $display("%0t ERROR: n=%0d r=%0d overflow: expected %0b, got %0b",
                         $time, a.n, a.r, a.overflow, ovf);
                mismatches++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block under test
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    binc_in_if  req_ch ();
    binc_out_if res_ch ();

    binomial_coefficient_checked_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    coefficient_ledger ledger;

    // idle odds in percent, changed per phase by the main sequence
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int quiet_cycles    = 0;

    // ------------------------------------------------------------------------
    // Result side: sample a beat at the edge, then pick ready for the next
    // cycle. One nonblocking write to ready per edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            ledger.check_result(res_ch.coefficient, res_ch.overflow);
        end
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Watchdog: any beat on either channel resets the count.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("%0t ERROR: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("binomial_coefficient_checked_core_test: done, errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side: optional gap cycles with valid low, then hold the beat
    // until ready. Back-to-back beats keep valid high across the boundary.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [N_BITS-1:0] n, input logic [N_BITS-1:0] r);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.set_size     <= n;
        req_ch.choose_count <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        ledger.note_request(n, r);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [N_BITS-1:0] n;
        logic [N_BITS-1:0] r;
        ledger = new();

        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.set_size     = '0;
        req_ch.choose_count = '0;
        res_ch.ready        = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: trivial cases (r > n, r = 0, r = n), field extremes, the
        // n-r < r reduction, and both sides of the overflow test.
        send_request(0, 0);
        send_request(0, 1);
        send_request(1, 0);
        send_request(1, 1);
        send_request(5, 7);
        send_request(0, N_MAX);
        send_request(N_MAX, N_MAX);
        send_request(N_MAX, 0);
        send_request(N_MAX, 1);
        send_request(N_MAX, N_MAX - 1);   // reduces to k = 1
        send_request(N_MAX, 2);           // product stays under the limit
        send_request(N_MAX, 3);           // trips on the third factor
        send_request(N_MAX, N_MAX - 2);
        send_request(10, 3);
        send_request(10, 7);
        send_request(20, 10);
        send_request(62, 31);
        send_request(66, 33);
        send_request(67, 33);
        send_request(30, 28);
        send_request(100, 50);
        send_request(1000, 5);
        send_request(31'h2AAA_AAAA, 31'h5555_5555);
        send_request(31'h5555_5555, 31'h2AAA_AAAA);

        // Random phases: free flow, sender gaps, receiver stalls, then both.
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = (ph == 1) ? 59 : (ph == 3) ? 10 : 0;
            recv_stall_pct  = (ph == 2) ? 59 : (ph == 3) ? 10 : 0;
            for (int j = 0; j < RANDOM_ITEMS / 4; j++) begin
                case ($urandom_range(9))
                    0, 1, 2: begin  // small n, r around 0..n, some r > n
                        n = N_BITS'($urandom_range(70));
                        r = N_BITS'($urandom_range(n + 3));
                    end
                    3, 4: begin     // huge n, short product
                        n = N_BITS'($urandom);
                        r = N_BITS'($urandom_range(3));
                    end
                    5: begin        // r close to n, exercises the reduction
                        n = N_BITS'($urandom);
                        r = N_BITS'(n - $urandom_range(3));
                    end
                    6: begin        // full-range noise
                        n = N_BITS'($urandom);
                        r = N_BITS'($urandom);
                    end
                    7: begin        // moderate n, k up to about 25
                        n = N_BITS'($urandom_range(1000));
                        r = N_BITS'($urandom_range(25));
                    end
                    8: begin        // central coefficients near the limit
                        n = N_BITS'($urandom_range(70, 50));
                        r = N_BITS'(n / 2 + $urandom_range(4) - 2);
                    end
                    default: begin  // large r with r > n
                        r = N_BITS'($urandom | 32'h4000_0000);
                        n = N_BITS'($urandom_range(r - 1));
                    end
                endcase
                send_request(n, r);
            end
        end
        req_ch.valid <= 1'b0;

        // drain: every awaited beat, then a quiet window for strays
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (ledger.mismatches == 0) begin
            $display("binomial_coefficient_checked_core_test: done, clean");
        end else begin
            $display("binomial_coefficient_checked_core_test: done, errors");
        end
        $finish;
    end

endmodule
